// ===== hw/rtl/bit_run_length_encoder_macros.svh =====
// ----------------------------------------------------------------------------
// bit_run_length_encoder_macros
// Assertion macros shared by the run-length encoder RTL.
// ----------------------------------------------------------------------------
`ifndef BIT_RUN_LENGTH_ENCODER_MACROS_SVH
`define BIT_RUN_LENGTH_ENCODER_MACROS_SVH

`ifndef SYNTHESIS
// checked while out of reset
`define BRLE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define BRLE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BRLE_ASSERT(lbl, prop, msg)
`define BRLE_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== hw/rtl/brle_pkg.sv =====
// ----------------------------------------------------------------------------
// brle_pkg
// Types, constants and helpers of the bit run-length encoder.
// ----------------------------------------------------------------------------
package brle_pkg;

    localparam logic signed [7:0] RUN_LIMIT_RESET     = 8'sd127;
    localparam logic signed [7:0] RUN_LIMIT_MIN_CODE  = -8'sd128;
    localparam int                QUEUE_DEPTH_DEFAULT = 4;

    typedef struct packed {
        logic signed [7:0] code;
        logic              value;
        logic              last;
    } result_t;

    // one accepted bit produces zero, one or two codes; an entry holds one or two
    typedef struct packed {
        logic    two;
        result_t r0;
        result_t r1;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic result_t make_result(logic value, logic [7:0] len, logic last);
        result_t r;
        r.code  = signed'(len ^ 8'h80);
        r.value = value;
        r.last  = last;
        return r;
    endfunction

endpackage

// ===== hw/rtl/brle_in_if.sv =====
// ----------------------------------------------------------------------------
// brle_in_if
// Input bit channel: one bit and its end-of-vector flag per beat.
// ----------------------------------------------------------------------------
interface brle_in_if;
    logic valid;
    logic ready;
    logic bit_value;
    logic end_of_vector;

    modport source (output valid, output bit_value, output end_of_vector, input ready);
    modport sink   (input valid, input bit_value, input end_of_vector, output ready);
endinterface

// ===== hw/rtl/brle_out_if.sv =====
// ----------------------------------------------------------------------------
// brle_out_if
// Output code channel: one run code per beat.
// ----------------------------------------------------------------------------
interface brle_out_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] run_code;
    logic              run_value;
    logic              last;

    modport source (output valid, output run_code, output run_value, output last,
                    input ready);
    modport sink   (input valid, input run_code, input run_value, input last,
                    output ready);
endinterface

// ===== hw/rtl/brle_cfg_if.sv =====
// ----------------------------------------------------------------------------
// brle_cfg_if
// Configuration write channel for the run_limit register.
// ----------------------------------------------------------------------------
interface brle_cfg_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/brle_front.sv =====
// ----------------------------------------------------------------------------
// brle_front
// Takes bits, tracks the current run and turns each bit into queue entries.
// ----------------------------------------------------------------------------
module brle_front (
    input  logic                   clk,
    input  logic                   rst_n,
    brle_in_if.sink                in_bits,
    brle_cfg_if.sink               cfg,
    input  brle_pkg::queue_status_t qstat,
    output logic                   push,
    output brle_pkg::entry_t       push_entry
);
    import brle_pkg::*;

    logic signed [7:0] limit_reg;
    logic              phase_reg, phase_next;
    logic [7:0]        len_reg, len_next;

    logic       accept;
    logic [7:0] cap;
    logic       trans;
    logic [7:0] len1, len2;
    logic       capped;
    logic       p2;
    logic       tail;
    logic       has_any;
    result_t    res_a, res_b, res_c;
    entry_t     entry;

    assign cfg.ready     = 1'b1;
    assign in_bits.ready = !qstat.full;
    assign accept        = in_bits.valid && in_bits.ready;

    always_comb
    begin
        // pattern 0x80 acts as -127, cap of one
        cap    = (limit_reg == RUN_LIMIT_MIN_CODE) ? 8'd1 : (8'(limit_reg) ^ 8'h80);
        trans  = in_bits.bit_value != phase_reg;
        len1   = trans ? 8'd1 : (len_reg + 8'd1);
        capped = len1 >= cap;
        len2   = capped ? 8'd0 : len1;
        p2     = capped ? ~in_bits.bit_value : in_bits.bit_value;
        tail   = in_bits.end_of_vector && (len2 != 8'd0);

        res_a = make_result(phase_reg, len_reg, 1'b0);
        res_b = make_result(in_bits.bit_value, len1, 1'b0);
        res_c = make_result(p2, len2, 1'b1);

        if (trans)
        begin
            has_any   = 1'b1;
            entry.two = capped || tail;
            entry.r0  = res_a;
            entry.r1  = capped ? res_b : res_c;
        end
        else
        begin
            has_any   = capped || tail;
            entry.two = 1'b0;
            entry.r0  = capped ? res_b : res_c;
            entry.r1  = res_c;
        end

        // final code of the stream carries last
        if (entry.two)
            entry.r1.last = in_bits.end_of_vector;
        else
            entry.r0.last = in_bits.end_of_vector;
    end

    assign push       = accept && has_any;
    assign push_entry = entry;

    always_comb
    begin
        phase_next = phase_reg;
        len_next   = len_reg;
        if (accept)
        begin
            if (in_bits.end_of_vector)
            begin
                phase_next = 1'b0;
                len_next   = 8'd0;
            end
            else
            begin
                phase_next = p2;
                len_next   = len2;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= RUN_LIMIT_RESET;
            phase_reg <= 1'b0;
            len_reg   <= 8'd0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                limit_reg <= cfg.data;
            phase_reg <= phase_next;
            len_reg   <= len_next;
        end
    end

endmodule

// ===== hw/rtl/brle_queue.sv =====
// ----------------------------------------------------------------------------
// brle_queue
// Small register FIFO of code entries between front and back.
// ----------------------------------------------------------------------------
`include "bit_run_length_encoder_macros.svh"

module brle_queue #(
    parameter int DEPTH = brle_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  brle_pkg::entry_t        push_entry,
    input  logic                    pop,
    output brle_pkg::entry_t        head,
    output brle_pkg::queue_status_t qstat
);
    import brle_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign qstat.full  = count_reg == CNT_W'(DEPTH);
    assign qstat.empty = count_reg == '0;
    assign head        = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `BRLE_ASSERT(a_no_push_full, push |-> !qstat.full, "push into full queue")
    `BRLE_ASSERT(a_no_pop_empty, pop |-> !qstat.empty, "pop from empty queue")
    `BRLE_ASSERT_ALWAYS(a_count_range, !rst_n || (count_reg <= CNT_W'(DEPTH)), "queue count overflow")

endmodule

// ===== hw/rtl/brle_back.sv =====
// ----------------------------------------------------------------------------
// brle_back
// Drives the codes of the head entry out, one code per beat.
// ----------------------------------------------------------------------------
`include "bit_run_length_encoder_macros.svh"

module brle_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  brle_pkg::entry_t        head,
    input  brle_pkg::queue_status_t qstat,
    output logic                    pop,
    brle_out_if.source              runs
);
    import brle_pkg::*;

    logic    sel_reg, sel_next;
    logic    fire;
    result_t cur;

    assign cur            = sel_reg ? head.r1 : head.r0;
    assign runs.valid     = !qstat.empty;
    assign runs.run_code  = cur.code;
    assign runs.run_value = cur.value;
    assign runs.last      = cur.last;

    assign fire = runs.valid && runs.ready;
    assign pop  = fire && (sel_reg || !head.two);

    always_comb
    begin
        sel_next = sel_reg;
        if (fire)
            sel_next = !pop;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sel_reg <= 1'b0;
        else
            sel_reg <= sel_next;
    end

    `BRLE_ASSERT(a_sel_two, sel_reg |-> (head.two && !qstat.empty), "second code without entry")

endmodule

// ===== hw/rtl/bit_run_length_encoder.sv =====
// A code is written to the queue when its bit is taken; runs offers it from the queue head.
// Throughput: one bit per cycle if not stalled; one beat per code on the single runs port.
// Bits causing two codes are absorbed by the QUEUE_DEPTH-entry queue; in_bits stalls when full.
// Reset (rst_n low, async): run state and queue cleared, run_limit back to 127.
// No clearing pass; the block takes bits right after reset.
// ----------------------------------------------------------------------------
// bit_run_length_encoder
// Alternating run-length encoder for a bit stream, front / queue / back.
// ----------------------------------------------------------------------------
module bit_run_length_encoder #(
    parameter int QUEUE_DEPTH = brle_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    brle_cfg_if.sink    cfg,
    brle_in_if.sink     in_bits,
    brle_out_if.source  runs
);
    import brle_pkg::*;

    logic          push;
    logic          pop;
    entry_t        push_entry;
    entry_t        head;
    queue_status_t qstat;

    brle_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_bits    (in_bits),
        .cfg        (cfg),
        .qstat      (qstat),
        .push       (push),
        .push_entry (push_entry)
    );

    brle_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .qstat      (qstat)
    );

    brle_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .qstat (qstat),
        .pop   (pop),
        .runs  (runs)
    );

endmodule

// ===== tb/tb_bit_run_length_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bit_run_length_encoder
// Self-checking bench for the alternating bit run-length encoder. Bits go in
// over the input channel and an in-bench run tracker predicts every code.
// The codes on the output channel are compared field by field, in order.
// Directed streams cover long runs, streams that open with a one,
// runs that hit the cap, the smallest caps, and a limit lowered mid-run.
// Random streams then follow under a range of limits. Both channels stall
// at random.
// ----------------------------------------------------------------------------
module tb_bit_run_length_encoder;

    import brle_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 4;

    logic clk;
    logic rst_n;

    brle_cfg_if cfg_ch ();
    brle_in_if  in_ch ();
    brle_out_if out_ch ();

    bit_run_length_encoder i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_ch),
        .in_bits (in_ch),
        .runs    (out_ch)
    );

    // run tracker state
    logic signed [7:0] limit_reg;
    logic              cur_value;
    logic [7:0]        cur_length;

    result_t expected_codes[$];
    int      fail_count;
    int      bits_sent;
    int      idle_cycles;
    int      out_stall;
    bit      steady;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // run tracker
    // ------------------------------------------------------------------------
    function automatic int cap_now();
        int lim;
        lim = limit_reg;
        if (lim < -127)
            lim = -127;   // 0x80 behaves as -127
        return lim + 128;
    endfunction

    function automatic result_t pack_run(input logic v, input logic [7:0] len,
                                         input logic fin);
        result_t r;
        r.code  = 8'(int'(len) - 128);
        r.value = v;
        r.last  = fin;
        return r;
    endfunction

    task automatic encode_bit(input logic b, input logic fin);
        result_t codes[2];
        int      n;
        int      cap;
        n   = 0;
        cap = cap_now();
        if (b != cur_value)
        begin
            codes[n]   = pack_run(cur_value, cur_length, 1'b0);
            n++;
            cur_value  = ~cur_value;
            cur_length = '0;
        end
        cur_length = cur_length + 8'd1;
        if (int'(cur_length) >= cap)
        begin
            codes[n]   = pack_run(cur_value, cur_length, 1'b0);
            n++;
            cur_value  = ~cur_value;
            cur_length = '0;
        end
        if (fin)
        begin
            if (cur_length != 0)
            begin
                codes[n] = pack_run(cur_value, cur_length, 1'b1);
                n++;
            end
            else if (n > 0)
            begin
                codes[n - 1].last = 1'b1;
            end
            cur_value  = 1'b0;
            cur_length = '0;
        end
        for (int k = 0; k < n; k++)
            expected_codes = {expected_codes, codes[k]};
    endtask

    // ------------------------------------------------------------------------
    // shared helpers
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        $display("%0t ERROR %s", $time, msg);
        fail_count++;
    endtask

    function automatic int pick_idle();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_bit(input logic b, input logic fin);
        int gap;
        gap = pick_idle();
        @(negedge clk);
        if (gap > 0)
        begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid         = 1'b1;
        in_ch.bit_value     = b;
        in_ch.end_of_vector = fin;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        encode_bit(b, fin);
        bits_sent++;
    endtask

    task automatic send_run(input logic v, input int len, input bit fin);
        for (int k = 0; k < len; k++)
            send_bit(v, fin && (k == len - 1));
    endtask

    task automatic stop_input();
        @(negedge clk);
        in_ch.valid = 1'b0;
    endtask

    // sender holds off until every predicted code has come out
    task automatic wait_drained();
        stop_input();
        while (expected_codes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic signed [7:0] v);
        wait_drained();
        @(negedge clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.data  = v;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        limit_reg = v;
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // reset limit: a long uncapped run, then a stream that opens with the
    // zero-length code
    task automatic test_long_run();
        send_run(1'b0, 40, 1'b0);
        send_run(1'b1, 3, 1'b1);
        send_run(1'b1, 2, 1'b1);
    endtask

    task automatic test_stream_start();
        send_bit(1'b0, 1'b1);
        send_bit(1'b1, 1'b1);
        send_run(1'b1, 2, 1'b0);
        send_run(1'b0, 2, 1'b0);
        send_bit(1'b1, 1'b1);
    endtask

    task automatic test_cap_hits();
        write_limit(-8'sd125);
        send_run(1'b0, 3, 1'b1);           // cap lands on the final bit
        send_run(1'b0, 4, 1'b0);           // repeat after cap: empty ones run
        send_bit(1'b1, 1'b1);
        send_run(1'b1, 4, 1'b1);
    endtask

    task automatic test_min_limit();
        write_limit(8'sh80);
        send_run(1'b0, 2, 1'b0);
        send_run(1'b1, 2, 1'b0);
        send_bit(1'b0, 1'b1);
        write_limit(-8'sd127);
        send_bit(1'b1, 1'b0);
        send_bit(1'b0, 1'b1);
    endtask

    task automatic test_limit_lowered();
        write_limit(8'sd127);
        send_run(1'b0, 12, 1'b0);
        write_limit(-8'sd124);
        send_bit(1'b0, 1'b0);              // run of 13 against a cap of 4
        send_bit(1'b1, 1'b1);
    endtask

    task automatic send_stream(input int cap, input bit close);
        int   n_runs;
        int   len;
        logic v;
        n_runs = $urandom_range(1, 5);
        v      = 1'($urandom_range(0, 1));
        for (int k = 0; k < n_runs; k++)
        begin
            if (cap <= 40 && $urandom_range(0, 4) == 0)
                len = $urandom_range(cap > 1 ? cap - 1 : 1, cap + 1);
            else
                len = $urandom_range(1, cap < 6 ? cap + 2 : 6);
            send_run(v, len, close && (k == n_runs - 1));
            v = ~v;
        end
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 8);
        for (int k = 0; k < n; k++)
            send_bit(1'($urandom_range(0, 1)), $urandom_range(0, 9) == 0);
    endtask

    task automatic test_random();
        logic signed [7:0] limits[9] = '{8'sh80, -8'sd127, -8'sd126, -8'sd124,
                                         -8'sd120, -8'sd100, 8'sd0, 8'sd0,
                                         8'sd127};
        int                stop_at;
        limits[7] = 8'($urandom_range(0, 255));
        for (int p = 0; p < 9; p++)
        begin
            write_limit(limits[p]);
            steady  = (p == 2) || ($urandom_range(0, 3) == 0);
            stop_at = bits_sent + 10;
            while (bits_sent < stop_at)
            begin
                if ($urandom_range(0, 6) == 0)
                    send_noise();
                else
                    send_stream(cap_now(), $urandom_range(0, 4) != 0);
                if ($urandom_range(0, 7) == 0)
                    wait_drained();
            end
            steady = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------------
    // output side: random backpressure, code check, watchdog
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (out_stall > 0)
        begin
            out_ch.ready = 1'b0;
            out_stall--;
        end
        else
        begin
            out_ch.ready = 1'b1;
            if ($urandom_range(0, 3) == 0)
                out_stall = pick_idle();
        end
    end

    always @(posedge clk)
    begin : check_codes
        result_t want;
        if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            if (expected_codes.size() == 0)
            begin
                report_mismatch($sformatf("unexpected beat: code %0d value %b last %b",
                                          out_ch.run_code, out_ch.run_value,
                                          out_ch.last));
            end
            else
            begin
                want = expected_codes.pop_front();
                if (out_ch.run_code !== want.code)
                    report_mismatch($sformatf("run_code %0d, expected %0d",
                                              out_ch.run_code, want.code));
                if (out_ch.run_value !== want.value)
                    report_mismatch($sformatf("run_value %b, expected %b",
                                              out_ch.run_value, want.value));
                if (out_ch.last !== want.last)
                    report_mismatch($sformatf("last %b, expected %b",
                                              out_ch.last, want.last));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
                   || (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
                   || (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("bit_run_length_encoder verification failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial
    begin
        clk                 = 1'b0;
        rst_n               = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.bit_value     = 1'b0;
        in_ch.end_of_vector = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.data         = '0;
        limit_reg           = RUN_LIMIT_RESET;
        cur_value           = 1'b0;
        cur_length          = '0;
        bits_sent           = 0;
        steady              = 1'b0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_long_run();
        test_stream_start();
        test_cap_hits();
        test_min_limit();
        test_limit_lowered();
        test_random();

        stop_input();
        while (expected_codes.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (fail_count == 0)
            $display("bit_run_length_encoder verification clean");
        else
            $display("bit_run_length_encoder verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/brle_pkg.sv
hw/rtl/brle_in_if.sv
hw/rtl/brle_out_if.sv
hw/rtl/brle_cfg_if.sv
hw/rtl/brle_front.sv
hw/rtl/brle_queue.sv
hw/rtl/brle_back.sv
hw/rtl/bit_run_length_encoder.sv
tb/tb_bit_run_length_encoder.sv
